[hdl/wft_pkg.sv]
package wft_pkg;

    localparam int VALUE_W     = 20;
    localparam int ADDR_W      = 20;
    localparam int IDX_W       = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int SEQ_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_OUT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAN_COUNT = 2'd1;

    localparam logic [SEQ_W-1:0] TILE_LAST = 4'd15;

endpackage

[hdl/wft_filter_if.sv]
interface wft_filter_if #(
    parameter int TAP_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [TAP_BITS-1:0]    tap_r0c0;
    logic signed [TAP_BITS-1:0]    tap_r0c1;
    logic signed [TAP_BITS-1:0]    tap_r0c2;
    logic signed [TAP_BITS-1:0]    tap_r1c0;
    logic signed [TAP_BITS-1:0]    tap_r1c1;
    logic signed [TAP_BITS-1:0]    tap_r1c2;
    logic signed [TAP_BITS-1:0]    tap_r2c0;
    logic signed [TAP_BITS-1:0]    tap_r2c1;
    logic signed [TAP_BITS-1:0]    tap_r2c2;
    logic [wft_pkg::IDX_W-1:0]     filter_index;
    logic [wft_pkg::IDX_W-1:0]     channel_index;

    modport source (
        output valid, tap_r0c0, tap_r0c1, tap_r0c2, tap_r1c0, tap_r1c1, tap_r1c2,
               tap_r2c0, tap_r2c1, tap_r2c2, filter_index, channel_index,
        input  ready
    );

    modport sink (
        input  valid, tap_r0c0, tap_r0c1, tap_r0c2, tap_r1c0, tap_r1c1, tap_r1c2,
               tap_r2c0, tap_r2c1, tap_r2c2, filter_index, channel_index,
        output ready
    );
endinterface

[hdl/wft_tile_if.sv]
interface wft_tile_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wft_pkg::VALUE_W-1:0]   tile_value;
    logic [1:0]                           tile_row;
    logic [1:0]                           tile_col;
    logic [wft_pkg::ADDR_W-1:0]           dest_address;
    logic                                 last_of_tile;

    modport source (
        output valid, tile_value, tile_row, tile_col, dest_address, last_of_tile,
        input  ready
    );

    modport sink (
        input  valid, tile_value, tile_row, tile_col, dest_address, last_of_tile,
        output ready
    );
endinterface

[hdl/wft_cfg.sv]
module wft_cfg #(
    parameter int MAX_FILTERS  = 256,
    parameter int MAX_CHANNELS = 256,
    parameter int OCNT_W       = 9,
    parameter int CCNT_W       = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wft_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [OCNT_W-1:0]                   out_count,
    output logic [CCNT_W-1:0]                   chan_count
);
    logic [OCNT_W-1:0] out_count_reg;
    logic [OCNT_W-1:0] out_count_next;
    logic [CCNT_W-1:0] chan_count_reg;
    logic [CCNT_W-1:0] chan_count_next;
    logic [OCNT_W-1:0] out_sat;
    logic [CCNT_W-1:0] chan_sat;

    // Writes above the supported maximum saturate to it.
    always_comb
    begin
        out_sat  = (int'(cfg_wdata) > MAX_FILTERS) ? OCNT_W'(MAX_FILTERS) : OCNT_W'(cfg_wdata);
        chan_sat = (int'(cfg_wdata) > MAX_CHANNELS) ? CCNT_W'(MAX_CHANNELS)
                                                    : CCNT_W'(cfg_wdata);
        out_count_next  = out_count_reg;
        chan_count_next = chan_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wft_pkg::REG_OUT_COUNT:  out_count_next  = out_sat;
                wft_pkg::REG_CHAN_COUNT: chan_count_next = chan_sat;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg  <= OCNT_W'(MAX_FILTERS);
            chan_count_reg <= CCNT_W'(MAX_CHANNELS);
        end
        else
        begin
            out_count_reg  <= out_count_next;
            chan_count_reg <= chan_count_next;
        end
    end

    assign out_count  = out_count_reg;
    assign chan_count = chan_count_reg;
endmodule

[hdl/wft_eval.sv]
module wft_eval #(
    parameter int TAP_BITS = 16,
    parameter int CALC_W   = 20
) (
    input  logic signed [TAP_BITS-1:0]  taps [3][3],
    input  logic [1:0]                  row,
    input  logic [1:0]                  col,
    output logic signed [CALC_W-1:0]    value
);
    logic signed [CALC_W-1:0] col_term [3];

    // One row (or column) of the doubled transform matrix applied to three values.
    function automatic logic signed [CALC_W-1:0] hcomb(
        input logic signed [CALC_W-1:0] a,
        input logic signed [CALC_W-1:0] b,
        input logic signed [CALC_W-1:0] c,
        input logic [1:0]               sel
    );
        logic signed [CALC_W-1:0] r;
        case (sel)
            2'd0:    r = a <<< 1;
            2'd1:    r = a + b + c;
            2'd2:    r = a - b + c;
            default: r = c <<< 1;
        endcase
        return r;
    endfunction

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            col_term[j] = hcomb(CALC_W'(taps[0][j]), CALC_W'(taps[1][j]),
                                CALC_W'(taps[2][j]), row);
        end
        value = hcomb(col_term[0], col_term[1], col_term[2], col);
    end
endmodule

[hdl/winograd_filter_transform_core.sv]
// Winograd F(2x2,3x3) filter transform. Each filter transaction (nine taps plus
// filter and channel numbers) produces sixteen tile transactions, row-major, each
// carrying four times the transformed coefficient as an exact integer and its
// address in the transposed layout; the sixteenth is flagged as last. The block
// emits one result per cycle through its single output channel while the sink is
// ready. The next filter is accepted in the cycle its predecessor's last result is
// issued, so filters stream back to back; the taps are captured on acceptance and
// each result then passes through the output register before it is presented.
module winograd_filter_transform_core #(
    parameter int MAX_FILTERS  = 256,
    parameter int MAX_CHANNELS = 256,
    parameter int TAP_BITS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wft_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    wft_filter_if.sink                          filter,
    wft_tile_if.source                          tile
);
    localparam int OCNT_W = ($clog2(MAX_FILTERS + 1) > wft_pkg::CFG_DATA_W)
                            ? $clog2(MAX_FILTERS + 1) : wft_pkg::CFG_DATA_W;
    localparam int CCNT_W = ($clog2(MAX_CHANNELS + 1) > wft_pkg::CFG_DATA_W)
                            ? $clog2(MAX_CHANNELS + 1) : wft_pkg::CFG_DATA_W;
    localparam int CALC_W = (TAP_BITS + 4 > wft_pkg::VALUE_W) ? TAP_BITS + 4
                                                               : wft_pkg::VALUE_W;
    localparam int PROD_W = wft_pkg::IDX_W + OCNT_W;

    logic [OCNT_W-1:0]                  out_count;
    logic [CCNT_W-1:0]                  chan_count;

    logic                               busy_reg;
    logic [wft_pkg::SEQ_W-1:0]          cnt_reg;
    logic signed [TAP_BITS-1:0]         tap_reg [3][3];
    logic [wft_pkg::ADDR_W-1:0]         oc_reg;
    logic [wft_pkg::ADDR_W-1:0]         addr_reg;

    logic                               out_valid_reg;
    logic signed [wft_pkg::VALUE_W-1:0] value_reg;
    logic [wft_pkg::SEQ_W-1:0]          pos_reg;
    logic [wft_pkg::ADDR_W-1:0]         dest_reg;
    logic                               last_reg;

    logic                               accept;
    logic                               advance;
    logic                               at_last;
    logic [PROD_W-1:0]                  co_prod;
    logic [PROD_W-1:0]                  base_sum;
    logic [OCNT_W+CCNT_W-1:0]           oc_prod;
    logic signed [CALC_W-1:0]           calc_value;

    wft_cfg #(
        .MAX_FILTERS  (MAX_FILTERS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .OCNT_W       (OCNT_W),
        .CCNT_W       (CCNT_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_count  (out_count),
        .chan_count (chan_count)
    );

    wft_eval #(
        .TAP_BITS (TAP_BITS),
        .CALC_W   (CALC_W)
    ) u_eval (
        .taps  (tap_reg),
        .row   (cnt_reg[3:2]),
        .col   (cnt_reg[1:0]),
        .value (calc_value)
    );

    assign at_last      = (cnt_reg == wft_pkg::TILE_LAST);
    assign advance      = busy_reg && (!out_valid_reg || tile.ready);
    assign filter.ready = !busy_reg || (advance && at_last);
    assign accept       = filter.valid && filter.ready;

    assign co_prod  = PROD_W'(filter.channel_index) * PROD_W'(out_count);
    assign base_sum = co_prod + PROD_W'(filter.filter_index);
    assign oc_prod  = (OCNT_W+CCNT_W)'(out_count) * (OCNT_W+CCNT_W)'(chan_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg + wft_pkg::SEQ_W'(1);
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tile.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tap_reg[0][0] <= filter.tap_r0c0;
            tap_reg[0][1] <= filter.tap_r0c1;
            tap_reg[0][2] <= filter.tap_r0c2;
            tap_reg[1][0] <= filter.tap_r1c0;
            tap_reg[1][1] <= filter.tap_r1c1;
            tap_reg[1][2] <= filter.tap_r1c2;
            tap_reg[2][0] <= filter.tap_r2c0;
            tap_reg[2][1] <= filter.tap_r2c1;
            tap_reg[2][2] <= filter.tap_r2c2;
            oc_reg        <= wft_pkg::ADDR_W'(oc_prod);
            addr_reg      <= wft_pkg::ADDR_W'(base_sum);
        end
        else if (advance)
        begin
            addr_reg <= addr_reg + oc_reg;
        end

        if (advance)
        begin
            value_reg <= calc_value[wft_pkg::VALUE_W-1:0];
            pos_reg   <= cnt_reg;
            dest_reg  <= addr_reg;
            last_reg  <= at_last;
        end
    end

    assign tile.valid        = out_valid_reg;
    assign tile.tile_value   = value_reg;
    assign tile.tile_row     = pos_reg[3:2];
    assign tile.tile_col     = pos_reg[1:0];
    assign tile.dest_address = dest_reg;
    assign tile.last_of_tile = last_reg;
endmodule

[hdl/wft_checker.sv]
module wft_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  out_row,
    input  logic [1:0]  out_col,
    input  logic        out_last
);
    // A result waiting for the sink holds its position.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col))
        else $error("tile transaction changed while stalled");

    // Only the bottom-right coefficient closes a tile.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_row == 2'd3 && out_col == 2'd3)))
        else $error("last flag does not match tile position");

    // Within a tile, results follow each other without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside a tile");

    // A freshly accepted filter blocks the input until its tile is nearly done.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("filter accepted while previous one has just started");
endmodule

bind winograd_filter_transform_core wft_checker u_wft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (filter.valid),
    .in_ready  (filter.ready),
    .out_valid (tile.valid),
    .out_ready (tile.ready),
    .out_row   (tile.tile_row),
    .out_col   (tile.tile_col),
    .out_last  (tile.last_of_tile)
);
